// ----- rtl/core/plsm_pkg.sv -----
// ============================================================================
// plsm_pkg
// Shared constants and types of the packet latency and sequence monitor.
// ============================================================================
`default_nettype none

package plsm_pkg;

    // Default histogram geometry.
    localparam int NUM_BINS_DEF   = 100;
    localparam int BIN_OFFSET_DEF = 10;

    // Depth of the result queue; it also bounds the transfers in flight.
    localparam int FIFO_DEPTH = 8;

    // floor(n / 1000) == (n * DIV_MS_MAGIC) >> DIV_MS_SHIFT for every
    // 32-bit unsigned n.
    localparam logic [31:0] DIV_MS_MAGIC = 32'd274877907;
    localparam int          DIV_MS_SHIFT = 38;
    localparam int          QUOT_W       = 64 - DIV_MS_SHIFT;

    typedef enum logic [2:0] {
        ST_FIRST        = 3'd0,
        ST_MEASURED     = 3'd1,
        ST_GAP          = 3'd2,
        ST_REPEATED     = 3'd3,
        ST_OUT_OF_ORDER = 3'd4,
        ST_BAD_ID       = 3'd5,
        ST_READOUT      = 3'd6
    } status_t;

    // Fields of a record that travel down the pipeline unchanged.
    typedef struct packed {
        status_t     status;
        logic [31:0] gap;
        logic [31:0] lat;
        logic [6:0]  bin;
        logic [31:0] rec_total;
        logic [31:0] missed_total;
    } item_t;

    // One finished result as it waits in the output queue.
    typedef struct packed {
        status_t     status;
        logic [31:0] gap;
        logic [31:0] lat;
        logic        new_max;
        logic        new_min;
        logic [31:0] bin_count;
        logic [31:0] rec_total;
        logic [31:0] missed_total;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/plsm_ram.sv -----
// ============================================================================
// plsm_ram
// Generic single-clock RAM with one write port and one registered read port.
// A read at the address being written returns the old contents.
// ============================================================================
`default_nettype none

module plsm_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/packet_latency_sequence_monitor_core.sv -----
// ============================================================================
// packet_latency_sequence_monitor_core
// Classifies test-packet records by sequence, measures latency of in-sequence
// records and keeps a millisecond latency histogram with running totals.
// ============================================================================
// Usage:
// Records enter on the in_valid/in_ready channel, one transfer per record.
// With mode low a record is analysed; with mode high the transfer reads one
// histogram bin (bin_index) together with the running totals. Every input
// transfer yields exactly one result transfer on out_valid/out_ready.
// The expected source id is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle; the block itself does not
// enforce this. It takes effect for the next record. Throughput is one
// record per cycle while in_ready is high: the histogram read-modify-write
// is spread over two pipeline stages with a one-entry write forwarding path.
// Results wait in an 8-entry queue; in_ready falls once 8 transfers are
// accepted but not yet delivered, so a stalled receiver backs up the input
// without losing anything, and the input keeps flowing while results wait.
// After reset a clearing pass writes zero into every histogram bin, one per
// cycle; in_ready stays low until it is done.
// ============================================================================
`default_nettype none

module packet_latency_sequence_monitor_core #(
    parameter int NUM_BINS   = plsm_pkg::NUM_BINS_DEF,
    parameter int BIN_OFFSET = plsm_pkg::BIN_OFFSET_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data,
    // Input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic [31:0]        source_id,
    input  wire logic [31:0]        frame_number,
    input  wire logic [31:0]        tx_time,
    input  wire logic [31:0]        rx_time,
    input  wire logic [6:0]         bin_index,
    // Result channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              status,
    output logic [31:0]             gap_frames,
    output logic signed [31:0]      latency_us,
    output logic                    new_max,
    output logic                    new_min,
    output logic [31:0]             bin_count,
    output logic [31:0]             records_total,
    output logic [31:0]             missed_total
);

    import plsm_pkg::*;

    localparam int ADDR_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = FIFO_AW + 1;

    localparam logic [31:0] NumBins32   = 32'(NUM_BINS);
    localparam logic [31:0] BinOffset32 = 32'(BIN_OFFSET);

    // ------------------------------------------------------------------------
    // Handshake bookkeeping
    // ------------------------------------------------------------------------
    logic               in_acc;
    logic               out_acc;
    logic [FIFO_CW-1:0] inflight_reg;
    logic [FIFO_CW-1:0] inflight_next;

    // Histogram clearing pass after reset.
    logic               clr_active_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    // Configuration register.
    logic [31:0]        expected_id_reg;

    // Stage 1: input register.
    logic               s1_valid_reg;
    logic               s1_mode_reg;
    logic [31:0]        s1_id_reg;
    logic [31:0]        s1_frame_reg;
    logic [31:0]        s1_tx_reg;
    logic [31:0]        s1_rx_reg;
    logic [6:0]         s1_bin_reg;

    // Sequence state.
    logic [31:0]        record_count_reg;
    logic [31:0]        record_count_next;
    logic [31:0]        missed_sum_reg;
    logic [31:0]        missed_sum_next;
    logic [31:0]        prev_frame_reg;
    logic [31:0]        prev_frame_next;
    logic [31:0]        base_diff_reg;
    logic [31:0]        base_diff_next;
    logic signed [31:0] latency_max_reg;
    logic signed [31:0] latency_min_reg;

    // Classification of the record in stage 1.
    item_t              s1_item;
    logic [31:0]        rx_minus_tx;
    logic [31:0]        missed;

    // Stage 2: classified record.
    logic               s2_valid_reg;
    item_t              s2_item_reg;
    logic               s2_measured;
    logic               s2_neg;
    logic [31:0]        s2_mag;
    logic               s2_new_max;
    logic               s2_new_min;

    // Stage 3: magnitude of the latency and extreme flags.
    logic               s3_valid_reg;
    item_t              s3_item_reg;
    logic               s3_neg_reg;
    logic [31:0]        s3_mag_reg;
    logic               s3_max_reg;
    logic               s3_min_reg;
    logic [63:0]        s3_prod;

    // Stage 4: latency in milliseconds (magnitude, truncated).
    logic               s4_valid_reg;
    item_t              s4_item_reg;
    logic               s4_neg_reg;
    logic [QUOT_W-1:0]  s4_q_reg;
    logic               s4_max_reg;
    logic               s4_min_reg;
    logic [31:0]        s4_q_ext;
    logic [31:0]        s4_idx_pos;
    logic [31:0]        s4_idx_neg;
    logic               s4_hit;
    logic               s4_inc;
    logic               s4_rd;
    logic [ADDR_W-1:0]  s4_addr;

    // Stage 5: histogram read-modify-write.
    logic               s5_valid_reg;
    item_t              s5_item_reg;
    logic               s5_max_reg;
    logic               s5_min_reg;
    logic               s5_inc_reg;
    logic               s5_rd_reg;
    logic [ADDR_W-1:0]  s5_addr_reg;
    logic [31:0]        s5_cur;
    result_t            s5_result;

    // Forwarding of the last histogram write.
    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic [31:0]        fwd_data_reg;

    // Histogram RAM ports.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;

    // Result queue.
    result_t            fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] fifo_wr_ptr_reg;
    logic [FIFO_AW-1:0] fifo_rd_ptr_reg;
    logic [FIFO_CW-1:0] fifo_cnt_reg;
    logic [FIFO_CW-1:0] fifo_cnt_next;
    result_t            out_result;

    // ------------------------------------------------------------------------
    // Input acceptance. The in-flight count covers every stage and the queue,
    // so the queue can never overflow while in_ready is high.
    // ------------------------------------------------------------------------
    assign in_ready = !clr_active_reg && (inflight_reg < FIFO_CW'(FIFO_DEPTH));
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;

    assign inflight_next = inflight_reg + FIFO_CW'(in_acc) - FIFO_CW'(out_acc);

    // ------------------------------------------------------------------------
    // Stage 1: classify the record and update the sequence state.
    // Only the difference of the two timebases matters for the latency, so
    // one register holds rx_base - tx_base.
    // ------------------------------------------------------------------------
    assign rx_minus_tx = s1_rx_reg - s1_tx_reg;
    // frame - previous - 1 written as one adder.
    assign missed      = s1_frame_reg + ~prev_frame_reg;

    always_comb
    begin
        s1_item              = '0;
        s1_item.status       = ST_BAD_ID;
        s1_item.bin          = s1_bin_reg;
        record_count_next    = record_count_reg;
        missed_sum_next      = missed_sum_reg;
        prev_frame_next      = prev_frame_reg;
        base_diff_next       = base_diff_reg;

        if (s1_valid_reg)
        begin
            if (s1_mode_reg)
            begin
                s1_item.status = ST_READOUT;
            end
            else if (s1_id_reg != expected_id_reg)
            begin
                s1_item.status = ST_BAD_ID;
            end
            else
            begin
                if (record_count_reg == 32'd0)
                begin
                    // First record, also after the record counter wraps.
                    s1_item.status = ST_FIRST;
                    base_diff_next = rx_minus_tx;
                end
                else if (s1_frame_reg < prev_frame_reg)
                begin
                    s1_item.status = ST_OUT_OF_ORDER;
                end
                else if (s1_frame_reg == prev_frame_reg)
                begin
                    s1_item.status = ST_REPEATED;
                end
                else if (missed != 32'd0)
                begin
                    s1_item.status  = ST_GAP;
                    s1_item.gap     = missed;
                    missed_sum_next = missed_sum_reg + missed;
                end
                else
                begin
                    s1_item.status = ST_MEASURED;
                    s1_item.lat    = rx_minus_tx - base_diff_reg;
                end
                prev_frame_next   = s1_frame_reg;
                record_count_next = record_count_reg + 32'd1;
            end
        end

        s1_item.rec_total    = record_count_next;
        s1_item.missed_total = missed_sum_next;
    end

    // ------------------------------------------------------------------------
    // Stage 2: running extremes, and the magnitude for the division.
    // ------------------------------------------------------------------------
    assign s2_measured = s2_valid_reg && (s2_item_reg.status == ST_MEASURED);
    assign s2_neg      = s2_item_reg.lat[31];
    assign s2_mag      = s2_neg ? (~s2_item_reg.lat + 32'd1) : s2_item_reg.lat;
    assign s2_new_max  = s2_measured && ($signed(s2_item_reg.lat) > latency_max_reg);
    assign s2_new_min  = s2_measured && ($signed(s2_item_reg.lat) < latency_min_reg);

    // ------------------------------------------------------------------------
    // Stage 3: divide the magnitude by 1000 with a reciprocal multiply.
    // ------------------------------------------------------------------------
    assign s3_prod = 64'(s3_mag_reg) * 64'(DIV_MS_MAGIC);

    // ------------------------------------------------------------------------
    // Stage 4: histogram index and read address. The quotient is truncated
    // toward zero, so a negative latency subtracts its magnitude.
    // ------------------------------------------------------------------------
    assign s4_q_ext   = 32'(s4_q_reg);
    assign s4_idx_pos = BinOffset32 + s4_q_ext;
    assign s4_idx_neg = BinOffset32 - s4_q_ext;

    always_comb
    begin
        if (s4_neg_reg)
        begin
            s4_hit = (s4_q_ext < BinOffset32) && (s4_idx_neg < NumBins32);
        end
        else
        begin
            s4_hit = (s4_idx_pos != 32'd0) && (s4_idx_pos < NumBins32);
        end
    end

    assign s4_inc  = (s4_item_reg.status == ST_MEASURED) && s4_hit;
    assign s4_rd   = (s4_item_reg.status == ST_READOUT) && (32'(s4_item_reg.bin) < NumBins32);
    assign s4_addr = (s4_item_reg.status == ST_READOUT) ? ADDR_W'(s4_item_reg.bin)
                   : s4_neg_reg                         ? ADDR_W'(s4_idx_neg)
                   :                                      ADDR_W'(s4_idx_pos);

    // ------------------------------------------------------------------------
    // Stage 5: the bin read in stage 4 arrives; the write of the record just
    // ahead is not yet in that data, so it is forwarded.
    // ------------------------------------------------------------------------
    assign s5_cur = (fwd_valid_reg && (fwd_addr_reg == s5_addr_reg)) ? fwd_data_reg
                                                                     : ram_rdata;

    always_comb
    begin
        s5_result              = '0;
        s5_result.status       = s5_item_reg.status;
        s5_result.gap          = s5_item_reg.gap;
        s5_result.lat          = s5_item_reg.lat;
        s5_result.new_max      = s5_max_reg;
        s5_result.new_min      = s5_min_reg;
        s5_result.bin_count    = s5_rd_reg ? s5_cur : 32'd0;
        s5_result.rec_total    = s5_item_reg.rec_total;
        s5_result.missed_total = s5_item_reg.missed_total;
    end

    assign ram_we    = clr_active_reg || (s5_valid_reg && s5_inc_reg);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s5_addr_reg;
    assign ram_wdata = clr_active_reg ? 32'd0 : (s5_cur + 32'd1);

    plsm_ram #(
        .WIDTH (32),
        .DEPTH (NUM_BINS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (s4_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Result queue.
    // ------------------------------------------------------------------------
    assign fifo_cnt_next = fifo_cnt_reg + FIFO_CW'(s5_valid_reg) - FIFO_CW'(out_acc);
    assign out_result    = fifo_mem[fifo_rd_ptr_reg];
    assign out_valid     = (fifo_cnt_reg != '0);

    assign status        = out_result.status;
    assign gap_frames    = out_result.gap;
    assign latency_us    = $signed(out_result.lat);
    assign new_max       = out_result.new_max;
    assign new_min       = out_result.new_min;
    assign bin_count     = out_result.bin_count;
    assign records_total = out_result.rec_total;
    assign missed_total  = out_result.missed_total;

    // ------------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg     <= '0;
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            expected_id_reg  <= 32'd1;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            record_count_reg <= 32'd0;
            missed_sum_reg   <= 32'd0;
            latency_max_reg  <= 32'sd0;
            latency_min_reg  <= 32'sd0;
            fwd_valid_reg    <= 1'b0;
            fifo_wr_ptr_reg  <= '0;
            fifo_rd_ptr_reg  <= '0;
            fifo_cnt_reg     <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;

            if (clr_active_reg)
            begin
                if (clr_addr_reg == ADDR_W'(NUM_BINS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end

            if (cfg_wr_en)
            begin
                expected_id_reg <= cfg_wr_data;
            end

            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;

            record_count_reg <= record_count_next;
            missed_sum_reg   <= missed_sum_next;

            if (s2_new_max)
            begin
                latency_max_reg <= $signed(s2_item_reg.lat);
            end
            if (s2_new_min)
            begin
                latency_min_reg <= $signed(s2_item_reg.lat);
            end

            if (s5_valid_reg && s5_inc_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end

            if (s5_valid_reg)
            begin
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + FIFO_AW'(1);
            end
            if (out_acc)
            begin
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_mode_reg  <= mode;
            s1_id_reg    <= source_id;
            s1_frame_reg <= frame_number;
            s1_tx_reg    <= tx_time;
            s1_rx_reg    <= rx_time;
            s1_bin_reg   <= bin_index;
        end

        prev_frame_reg <= prev_frame_next;
        base_diff_reg  <= base_diff_next;

        s2_item_reg <= s1_item;

        s3_item_reg <= s2_item_reg;
        s3_neg_reg  <= s2_neg;
        s3_mag_reg  <= s2_mag;
        s3_max_reg  <= s2_new_max;
        s3_min_reg  <= s2_new_min;

        s4_item_reg <= s3_item_reg;
        s4_neg_reg  <= s3_neg_reg;
        s4_q_reg    <= s3_prod[63:DIV_MS_SHIFT];
        s4_max_reg  <= s3_max_reg;
        s4_min_reg  <= s3_min_reg;

        s5_item_reg <= s4_item_reg;
        s5_max_reg  <= s4_max_reg;
        s5_min_reg  <= s4_min_reg;
        s5_inc_reg  <= s4_inc;
        s5_rd_reg   <= s4_rd;
        s5_addr_reg <= s4_addr;

        if (s5_valid_reg && s5_inc_reg)
        begin
            fwd_addr_reg <= s5_addr_reg;
            fwd_data_reg <= ram_wdata;
        end

        if (s5_valid_reg)
        begin
            fifo_mem[fifo_wr_ptr_reg] <= s5_result;
        end
    end

`ifndef NO_ASSERTIONS
    // The in-flight count never goes past the queue depth.
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("in-flight count exceeds the result queue depth");

    // Nothing enters or is in flight while the histogram is being cleared.
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!in_ready && (inflight_reg == '0)))
        else $error("record in flight during the histogram clearing pass");

    // A finished record always finds room in the queue.
    a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> (fifo_cnt_reg < FIFO_CW'(FIFO_DEPTH)) || out_acc)
        else $error("result queue overflow");

    // The queue holds only accepted, undelivered records.
    a_fifo_le_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= inflight_reg)
        else $error("result queue holds more than the in-flight count");

    // Every accepted record comes out of the pipeline, with no stage holding it back.
    a_pipe_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> ##5 s5_valid_reg)
        else $error("accepted record lost in the pipeline");
`endif

endmodule

`default_nettype wire

// ----- bench/plsm_tb_pkg.sv -----
// ============================================================================
// plsm_tb_pkg
// Record type and result ledger for the packet latency monitor testbench.
// ============================================================================

package plsm_tb_pkg;

    import plsm_pkg::*;

    localparam int US_PER_MS   = 1000;
    localparam int MAX_REPORTS = 10;

    typedef enum logic {
        MODE_ANALYSE = 1'b0,
        MODE_READOUT = 1'b1
    } mode_t;

    // One input transfer as the bench drives it.
    typedef struct {
        mode_t       mode;
        logic [31:0] source_id;
        logic [31:0] frame_number;
        logic [31:0] tx_time;
        logic [31:0] rx_time;
        logic [6:0]  bin_index;
    } record_t;

    // Tracks the monitor's sequence and latency state and holds the results
    // that accepted records are still owed.
    class latency_sequence_checker;

        logic [31:0] expected_id;
        logic [31:0] record_count;
        logic [31:0] missed_sum;
        int          lat_max;
        int          lat_min;
        logic [31:0] histogram [NUM_BINS_DEF];
        logic [31:0] prev_frame;
        logic [31:0] tx_base;
        logic [31:0] rx_base;
        result_t     owed_results [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned status_seen [8];
        int unsigned id_settings;

        function new();
            expected_id  = 32'd1;
            record_count = '0;
            missed_sum   = '0;
            lat_max      = 0;
            lat_min      = 0;
            prev_frame   = '0;
            tx_base      = '0;
            rx_base      = '0;
            mismatches   = 0;
            checked      = 0;
            id_settings  = 1;
            foreach (histogram[i])
                histogram[i] = '0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void set_expected_id(input logic [31:0] id);
            expected_id = id;
            id_settings++;
        endfunction

        // Classifies one accepted record and queues the result it must give.
        function void note_record(input record_t r);
            result_t     e;
            logic [31:0] rel_tx;
            logic [31:0] rel_rx;
            logic [31:0] diff;
            logic [31:0] missed;
            int          t;
            int          idx;
            e = '0;
            if (r.mode == MODE_READOUT)
            begin
                e.status = ST_READOUT;
                if (r.bin_index < NUM_BINS_DEF)
                    e.bin_count = histogram[r.bin_index];
            end
            else if (r.source_id != expected_id)
            begin
                e.status = ST_BAD_ID;
            end
            else
            begin
                if (record_count == '0)
                begin
                    e.status   = ST_FIRST;
                    tx_base    = r.tx_time;
                    rx_base    = r.rx_time;
                    prev_frame = r.frame_number;
                end
                else
                begin
                    rel_tx = r.tx_time - tx_base;
                    rel_rx = r.rx_time - rx_base;
                    if (r.frame_number < prev_frame)
                    begin
                        e.status = ST_OUT_OF_ORDER;
                    end
                    else if (r.frame_number == prev_frame)
                    begin
                        e.status = ST_REPEATED;
                    end
                    else
                    begin
                        missed = r.frame_number - prev_frame - 32'd1;
                        if (missed != '0)
                        begin
                            e.status   = ST_GAP;
                            e.gap      = missed;
                            missed_sum = missed_sum + missed;
                        end
                        else
                        begin
                            diff     = rel_rx - rel_tx;
                            t        = $signed(diff);
                            // Signed division truncates toward zero here.
                            idx      = t / US_PER_MS + BIN_OFFSET_DEF;
                            e.status = ST_MEASURED;
                            e.lat    = diff;
                            if (idx > 0 && idx < NUM_BINS_DEF)
                                histogram[idx] = histogram[idx] + 32'd1;
                            if (t > lat_max)
                            begin
                                lat_max   = t;
                                e.new_max = 1'b1;
                            end
                            if (t < lat_min)
                            begin
                                lat_min   = t;
                                e.new_min = 1'b1;
                            end
                        end
                    end
                    prev_frame = r.frame_number;
                end
                record_count = record_count + 32'd1;
            end
            e.rec_total    = record_count;
            e.missed_total = missed_sum;
            status_seen[int'(e.status)]++;
            owed_results.insert(owed_results.size(), e);
        endfunction

        function string describe(input result_t r);
            return $sformatf({"status %0d gap %0d latency %0d max %0b min %0b",
                              " bin %0d records %0d missed %0d"},
                             r.status, r.gap, $signed(r.lat), r.new_max,
                             r.new_min, r.bin_count, r.rec_total, r.missed_total);
        endfunction

        // Compares one delivered result with the oldest owed one.
        function void check_result(input result_t got);
            result_t e;
            string   wrong;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Result with nothing owed: %s", describe(got));
                return;
            end
            e = owed_results.pop_front();
            checked++;
            wrong = "";
            if (got.status !== e.status)             wrong = {wrong, " status"};
            if (got.gap !== e.gap)                   wrong = {wrong, " gap_frames"};
            if (got.lat !== e.lat)                   wrong = {wrong, " latency_us"};
            if (got.new_max !== e.new_max)           wrong = {wrong, " new_max"};
            if (got.new_min !== e.new_min)           wrong = {wrong, " new_min"};
            if (got.bin_count !== e.bin_count)       wrong = {wrong, " bin_count"};
            if (got.rec_total !== e.rec_total)       wrong = {wrong, " records_total"};
            if (got.missed_total !== e.missed_total) wrong = {wrong, " missed_total"};
            if (wrong != "")
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("Result %0d differs in%s", checked, wrong);
                    $display("  expected: %s", describe(e));
                    $display("  actual:   %s", describe(got));
                end
            end
        endfunction

        function int unsigned bins_hit();
            int unsigned n;
            n = 0;
            foreach (histogram[i])
                if (histogram[i] != '0)
                    n++;
            return n;
        endfunction

    endclass

endpackage

// ----- bench/tb_packet_latency_sequence_monitor_core.sv -----
// ============================================================================
// tb_packet_latency_sequence_monitor_core
// Self-checking bench for the packet latency and sequence monitor. A short
// directed sequence walks the record classes, histogram edges and latency
// extremes, then random phases under several expected ids stream mostly
// well-formed frame sequences mixed with repeats, reordering, gaps, foreign
// ids and histogram reads, with random idle cycles on both channels.
// ============================================================================

module tb_packet_latency_sequence_monitor_core;

    timeunit 1ns;
    timeprecision 1ps;

    import plsm_pkg::*;
    import plsm_tb_pkg::*;

    localparam int          RESET_CYCLES  = 8;
    // Extra idle time after the last owed result, before the next phase.
    localparam int          SETTLE_CYCLES = 10;
    localparam int          PHASES        = 5;
    localparam int          PHASE_ITEMS   = 106;
    localparam logic [31:0] DEFAULT_ID    = 32'd1;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic               mode;
    logic [31:0]        source_id;
    logic [31:0]        frame_number;
    logic [31:0]        tx_time;
    logic [31:0]        rx_time;
    logic [6:0]         bin_index;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic [31:0]        gap_frames;
    logic signed [31:0] latency_us;
    logic               new_max;
    logic               new_min;
    logic [31:0]        bin_count;
    logic [31:0]        records_total;
    logic [31:0]        missed_total;

    latency_sequence_checker ledger;

    // While this is set neither channel inserts idle cycles, so the pipeline
    // and the histogram forwarding path run back to back.
    bit calm;

    packet_latency_sequence_monitor_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .source_id     (source_id),
        .frame_number  (frame_number),
        .tx_time       (tx_time),
        .rx_time       (rx_time),
        .bin_index     (bin_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .gap_frames    (gap_frames),
        .latency_us    (latency_us),
        .new_max       (new_max),
        .new_min       (new_min),
        .bin_count     (bin_count),
        .records_total (records_total),
        .missed_total  (missed_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #2ms;
        $display("[packet_latency_sequence_monitor_core] ERROR");
        $finish;
    end

    // Every result transfer is checked against the oldest owed result.
    // Sampling right at the edge sees the values from before the edge.
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.status       = status_t'(status);
            got.gap          = gap_frames;
            got.lat          = latency_us;
            got.new_max      = new_max;
            got.new_min      = new_min;
            got.bin_count    = bin_count;
            got.rec_total    = records_total;
            got.missed_total = missed_total;
            ledger.check_result(got);
        end
    end

    // The receiver inserts a random stall ahead of each result it takes, unless calm is set.
    initial
    begin
        int unsigned stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
            begin
                @(posedge clk);
            end
        end
    end

    // Drives one record, after a random idle gap unless calm is set, and holds it until the
    // transfer happens. Valid is only lowered when an idle gap follows, so a
    // back-to-back record never sees valid dropped and raised in one step.
    task automatic send_record(input record_t r);
        int unsigned idle;
        idle = calm ? 0 : $urandom_range(0, 3);
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= r.mode;
        source_id    <= r.source_id;
        frame_number <= r.frame_number;
        tx_time      <= r.tx_time;
        rx_time      <= r.rx_time;
        bin_index    <= r.bin_index;
        @(posedge clk);
        while (in_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        ledger.note_record(r);
    endtask

    // Holds the input off until every owed result has been delivered.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (ledger.owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_expected_id(input logic [31:0] id);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ledger.set_expected_id(id);
    endtask

    // A histogram read; the record fields are noise the block must ignore.
    function automatic record_t readout(input logic [6:0] bin);
        record_t r;
        r.mode         = MODE_READOUT;
        r.source_id    = $urandom;
        r.frame_number = $urandom;
        r.tx_time      = $urandom;
        r.rx_time      = $urandom;
        r.bin_index    = bin;
        return r;
    endfunction

    function automatic record_t analysed(input logic [31:0] id, input logic [31:0] frame,
                                         input logic [31:0] tx, input logic [31:0] rx);
        record_t r;
        r.mode         = MODE_ANALYSE;
        r.source_id    = id;
        r.frame_number = frame;
        r.tx_time      = tx;
        r.rx_time      = rx;
        r.bin_index    = $urandom_range(0, 127);
        return r;
    endfunction

    // A record with the expected id whose timestamps, seen relative to the
    // captured timebases, differ by exactly lat microseconds.
    function automatic record_t timed(input logic [31:0] frame, input logic [31:0] rel_tx,
                                      input logic [31:0] lat);
        return analysed(ledger.expected_id, frame, ledger.tx_base + rel_tx,
                        ledger.rx_base + rel_tx + lat);
    endfunction

    // Mostly well-formed in-sequence traffic with latencies that land in the
    // histogram, plus gaps, repeats, reordering, foreign ids and reads.
    function automatic record_t random_record();
        int unsigned pick;
        logic [31:0] id;
        logic [31:0] prev;
        logic [31:0] frame;
        logic [31:0] lat;
        pick = $urandom_range(0, 99);
        prev = ledger.prev_frame;
        if (pick < 8)
        begin
            if ($urandom_range(0, 1) == 0)
                return readout($urandom_range(0, 127));
            return readout($urandom_range(8, 20));
        end
        if (pick < 15)
        begin
            id = $urandom;
            if (id == ledger.expected_id)
                id = id ^ 32'd1;
            return analysed(id, $urandom, $urandom, $urandom);
        end
        if (ledger.record_count == '0)
            return analysed(ledger.expected_id, $urandom, $urandom, $urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: lat = $urandom_range(0, 107000) - 12000;
            7, 8:                lat = $urandom_range(0, 100) - 50;
            default:             lat = $urandom;
        endcase
        if (pick < 70)
            frame = prev + 32'd1;
        else if (pick < 80)
            frame = ($urandom_range(0, 3) == 0) ? prev + $urandom
                                                : prev + 32'd2 + $urandom_range(0, 20);
        else if (pick < 88)
            frame = prev;
        else if (prev == '0)
            frame = $urandom;
        else
            frame = ($urandom_range(0, 1) == 0) ? prev - 32'd1 : $urandom_range(prev - 32'd1, 0);
        return timed(frame, $urandom, lat);
    endfunction

    initial
    begin
        logic [31:0] phase_ids [PHASES];
        ledger       = new();
        calm         = 1'b0;
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        in_valid     <= 1'b0;
        mode         <= MODE_ANALYSE;
        source_id    <= '0;
        frame_number <= '0;
        tx_time      <= '0;
        rx_time      <= '0;
        bin_index    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the id the register holds after reset.
        // Reads before any record must return zero, including bin numbers
        // past the end of the histogram.
        send_record(readout(7'd127));
        send_record(readout(7'd0));
        // Foreign ids leave all state alone.
        send_record(analysed(32'hFFFF_FFFF, 32'd5, 32'd0, 32'd0));
        send_record(analysed(32'h0000_0000, 32'd5, 32'd0, 32'd0));
        // The first record sets the timebases; the transmit base is chosen so
        // that later transmit times wrap.
        send_record(analysed(DEFAULT_ID, 32'd100, 32'hFFFF_FF00, 32'h0000_0100));
        send_record(timed(32'd101, 32'd1000, 32'd5000));
        // Negative latency below the histogram range, then the edges of the
        // counted range: bin 0 is never counted, bins 1 and 99 are.
        send_record(timed(32'd102, 32'd2000, -32'sd20000));
        send_record(timed(32'd103, 32'd3000, -32'sd10999));
        send_record(timed(32'd104, 32'd4000, -32'sd9000));
        send_record(timed(32'd105, 32'd5000, 32'd89999));
        send_record(timed(32'd106, 32'd6000, 32'd90000));
        // Extreme latencies, with the transmit offset itself wrapping.
        send_record(timed(32'd107, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send_record(timed(32'd108, 32'd7000, 32'h8000_0000));
        // Repeat, reorder, a small gap, back in sequence, then a gap up to
        // the top frame number and a wrap back to frame zero.
        send_record(timed(32'd108, 32'd7100, 32'd10));
        send_record(timed(32'd50, 32'd7200, 32'd10));
        send_record(timed(32'd60, 32'd7300, 32'd10));
        send_record(timed(32'd61, 32'd8000, 32'd999));
        send_record(timed(32'hFFFF_FFFF, 32'd9000, 32'd10));
        send_record(timed(32'd0, 32'd9100, 32'd10));
        send_record(readout(7'd1));
        send_record(readout(7'd10));
        send_record(readout(7'd15));
        send_record(readout(7'd99));
        send_record(readout(7'd100));
        // Let the pipeline and the result queue run completely dry once.
        wait_for_results();

        // Random phases. Each expected id is written while the block is idle;
        // the sequence state carries across the change.
        phase_ids[0] = 32'hFFFF_FFFF;
        phase_ids[1] = 32'h0000_0000;
        phase_ids[2] = $urandom;
        phase_ids[3] = DEFAULT_ID;
        phase_ids[4] = $urandom;
        for (int p = 0; p < PHASES; p++)
        begin
            write_expected_id(phase_ids[p]);
            calm = (p == 2);
            repeat (PHASE_ITEMS) send_record(random_record());
            wait_for_results();
        end
        calm = 1'b0;

        $display("Checked %0d results: %0d first, %0d measured, %0d gap, %0d repeated,",
                 ledger.checked, ledger.status_seen[ST_FIRST], ledger.status_seen[ST_MEASURED],
                 ledger.status_seen[ST_GAP], ledger.status_seen[ST_REPEATED]);
        $display("  %0d out of order, %0d foreign id, %0d reads; %0d bins filled, %0d ids used.",
                 ledger.status_seen[ST_OUT_OF_ORDER], ledger.status_seen[ST_BAD_ID],
                 ledger.status_seen[ST_READOUT], ledger.bins_hit(), ledger.id_settings);
        if (ledger.mismatches == 0 && ledger.owed_results.size() == 0)
        begin
            $display("[packet_latency_sequence_monitor_core] OK");
        end
        else
        begin
            $display("%0d bad results, %0d still owed", ledger.mismatches,
                     ledger.owed_results.size());
            $display("[packet_latency_sequence_monitor_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/plsm_pkg.sv
rtl/core/plsm_ram.sv
rtl/core/packet_latency_sequence_monitor_core.sv
bench/plsm_tb_pkg.sv
bench/tb_packet_latency_sequence_monitor_core.sv
